### sv/lla_pkg.sv
package lla_pkg;

  // Default grid limits
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;

  // Rule masks cover neighbour counts 0..8
  localparam int unsigned MaskW   = 9;
  localparam int unsigned CountW  = 4;
  localparam int unsigned CfgIdxW = 2;

  // One window column: current row, row above, row two above
  localparam int unsigned ColBits = 3;
  // Stored window columns behind the incoming one
  localparam int unsigned WinCells = 2;

  // Register reset values
  localparam logic [MaskW-1:0] RstSurvive    = 9'd12;
  localparam logic [MaskW-1:0] RstBirth      = 9'd8;
  localparam int unsigned      RstGridWidth  = 64;
  localparam int unsigned      RstGridHeight = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSurvive = 2'd0,
    CfgBirth   = 2'd1,
    CfgWidth   = 2'd2,
    CfgHeight  = 2'd3
  } cfg_idx_e;

  // Live cells in one window column
  function automatic logic [1:0] col_ones(logic [ColBits-1:0] col);
    col_ones = {1'b0, col[0]} + {1'b0, col[1]} + {1'b0, col[2]};
  endfunction

endpackage

### sv/lla_win_cell.sv
module lla_win_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic [lla_pkg::ColBits-1:0] col_i,
  output logic [lla_pkg::ColBits-1:0] col_o,
  output logic [1:0]                  ones_o
);
  import lla_pkg::*;

  logic [ColBits-1:0] col_q;

  // Column moves one place down the chain per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o  = col_q;
  assign ones_o = col_ones(col_q);

endmodule

### sv/lla_line_buf.sv
module lla_line_buf #(
  parameter int unsigned Depth = lla_pkg::DefMaxWidth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i
);
  // bit 0: row above, bit 1: row two above
  logic [1:0] mem [Depth];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/lla_out_fifo.sv
module lla_out_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o,
  output logic [1:0]       cnt_o
);
  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/life_like_automaton_window_step.sv
// Life-like cellular automaton, one generation per raster frame. Cells stream in on the slave
// side row by row, left to right, one per transfer, and the block sustains one cell per clock
// cycle while results are taken. Each cell is read against two line buffers (one memory, one
// read and one write port) and shifted into a 3x3 window held by a chain of column cells. For
// every interior cell one result transfer leaves once the cell below and to the right of it
// is accepted, carrying its row, column, live neighbour count and next state; tlast marks the
// final interior cell of a frame. Border rows and columns give no output. survive_mask and
// birth_mask select the rule (bit n set: n live neighbours keep or make a cell alive);
// grid_width and grid_height are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT, and writing either
// one restarts the frame at row 0, column 0. Write configuration only while the block is idle.
// A two-entry output queue lets input keep flowing while one result waits to be taken.
module life_like_automaton_window_step #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = lla_pkg::DefMaxHeight,
  parameter int unsigned CW         = $clog2(MAX_WIDTH),
  parameter int unsigned RW         = $clog2(MAX_HEIGHT),
  parameter int unsigned OUT_W      = ((RW + CW + 5 + 7) / 8) * 8,
  parameter int unsigned CFG_W      = (RW + 1 > lla_pkg::MaskW) ? RW + 1 : lla_pkg::MaskW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave side
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [0] cell_alive
  // master side
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OUT_W-1:0]            m_axis_tdata,  // cell_row, cell_col, neighbour_count,
                                                     // next_alive (lowest first)
  output logic                        m_axis_tlast,  // frame_last
  // configuration
  input  logic                        cfg_we_i,
  input  lla_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i
);
  import lla_pkg::*;

  localparam int unsigned WW   = CW + 1;
  localparam int unsigned HW   = RW + 1;
  localparam int unsigned PayW = RW + CW + CountW + 2;
  localparam int unsigned RstWM1 =
    (RstGridWidth > MAX_WIDTH) ? MAX_WIDTH - 1 : RstGridWidth - 1;
  localparam int unsigned RstHM1 =
    (RstGridHeight > MAX_HEIGHT) ? MAX_HEIGHT - 1 : RstGridHeight - 1;

  // Configuration registers
  logic [MaskW-1:0] survive_q, birth_q;
  logic [CW-1:0]    w_m1_q, w_m1_d;
  logic [RW-1:0]    h_m1_q, h_m1_d;

  // Raster position of the next input
  logic [CW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;

  // Line buffer stage
  logic             s1_valid_q, s1_res_q, s1_cell_q, s1_last_q;
  logic [CW-1:0]    s1_addr_q, s1_col_q;
  logic [RW-1:0]    s1_row_q;

  logic             accept, pop, push;
  logic [1:0]       rd_word;
  logic [1:0]       fifo_cnt, occ_nxt;
  logic [PayW-1:0]  res_data, fifo_data;
  logic             fifo_valid;

  logic [WW-1:0]    cfg_w;
  logic [HW-1:0]    cfg_h;

  logic [ColBits-1:0] win_col [WinCells+1];
  logic [1:0]         win_ones [WinCells];
  logic               centre, next_alive;
  logic [CountW-1:0]  n_count;
  logic [MaskW-1:0]   rule;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = fifo_valid && m_axis_tready;
  assign push   = s1_valid_q && s1_res_q;

  // Take a cell only if its result is sure to find room in the queue
  assign occ_nxt       = fifo_cnt + {1'b0, push} - {1'b0, pop};
  assign s_axis_tready = !occ_nxt[1];

  // Clamp grid size on write, keep size minus one
  assign cfg_w = cfg_data_i[WW-1:0];
  assign cfg_h = cfg_data_i[HW-1:0];

  always_comb begin
    if (cfg_w < WW'(3)) begin
      w_m1_d = CW'(2);
    end else if (cfg_w > WW'(MAX_WIDTH)) begin
      w_m1_d = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1_d = CW'(cfg_w - WW'(1));
    end
    if (cfg_h < HW'(3)) begin
      h_m1_d = RW'(2);
    end else if (cfg_h > HW'(MAX_HEIGHT)) begin
      h_m1_d = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1_d = RW'(cfg_h - HW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      survive_q <= RstSurvive;
      birth_q   <= RstBirth;
      w_m1_q    <= CW'(RstWM1);
      h_m1_q    <= RW'(RstHM1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSurvive: survive_q <= cfg_data_i[MaskW-1:0];
        CfgBirth:   birth_q   <= cfg_data_i[MaskW-1:0];
        CfgWidth:   w_m1_q    <= w_m1_d;
        CfgHeight:  h_m1_q    <= h_m1_d;
        default: ;
      endcase
    end
  end

  // Raster position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i && (cfg_idx_i == CfgWidth || cfg_idx_i == CfgHeight)) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == w_m1_q) begin
        col_d = '0;
        row_d = (row_q == h_m1_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Accept stage: tag the cell with its result coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s1_res_q   <= accept && (row_q >= RW'(2)) && (col_q >= CW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q <= s_axis_tdata[0];
      s1_addr_q <= col_q;
      s1_row_q  <= row_q - RW'(1);
      s1_col_q  <= col_q - CW'(1);
      s1_last_q <= (row_q == h_m1_q) && (col_q == w_m1_q);
    end
  end

  // Line buffers: read on accept, write back in the following cycle
  lla_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({rd_word[0], s1_cell_q})
  );

  // Window: incoming column plus a chain of stored columns
  assign win_col[0] = {rd_word[1], rd_word[0], s1_cell_q};

  for (genvar i = 0; i < WinCells; i++) begin : g_cell
    lla_win_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_valid_q),
      .col_i   (win_col[i]),
      .col_o   (win_col[i+1]),
      .ones_o  (win_ones[i])
    );
  end

  // Neighbour count and rule lookup
  assign centre  = win_col[1][1];
  assign n_count = {2'b00, col_ones(win_col[0])} + {2'b00, win_ones[0]}
                 + {2'b00, win_ones[1]} - {3'b000, centre};
  assign rule       = centre ? survive_q : birth_q;
  assign next_alive = rule[n_count];

  assign res_data = {s1_last_q, next_alive, n_count, s1_col_q, s1_row_q};

  lla_out_fifo #(
    .Width (PayW)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_data),
    .valid_o (fifo_valid),
    .ready_i (m_axis_tready),
    .data_o  (fifo_data),
    .cnt_o   (fifo_cnt)
  );

  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = OUT_W'(fifo_data[PayW-2:0]);
  assign m_axis_tlast  = fifo_data[PayW-1];

  // Queue is never full when a result arrives
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fifo_cnt == 2'd2) |-> !push)
    else $error("result queue overflow");

  // Every accepted cell is written back to the line buffers next cycle
  a_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("line buffer write-back missing");

  // Position stays inside the clamped grid
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= w_m1_q) && (row_q <= h_m1_q))
    else $error("raster position out of grid");

  // A result is only queued for a cell that was accepted
  a_push_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> $past(accept))
    else $error("result without accepted cell");

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lla_pkg::*;

  localparam int unsigned MaxWidth    = DefMaxWidth;
  localparam int unsigned MaxHeight   = DefMaxHeight;
  // row 12 + col 10 + count 4 + next 1 bits, padded to whole bytes
  localparam int unsigned OutW        = 32;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned GapPct      = 38;
  localparam int unsigned WideCells   = 64;
  localparam int unsigned TallCells   = 300;
  localparam int unsigned RandomCells = 1260;

  typedef struct packed {
    logic [11:0] row;
    logic [9:0]  col;
    logic [3:0]  count;
    logic        next;
    logic        last;
  } cell_update_t;

  // one directed 3x3 frame: cells in raster order, plus the known outcome of its centre
  typedef struct packed {
    logic [8:0] cells;
    logic [3:0] count;
    logic       next;
  } frame_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [7:0]      s_axis_tdata;   // [0] cell_alive
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [OutW-1:0] m_axis_tdata;   // cell_row, cell_col, neighbour_count, next_alive
  logic            m_axis_tlast;   // frame_last
  logic            cfg_we_i;
  cfg_idx_e        cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  life_like_automaton_window_step uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Grid model: line buffers, window, raster position and registers
  bit          above_row     [MaxWidth];
  bit          two_above_row [MaxWidth];
  logic [8:0]  window_q;
  int unsigned row_pos;
  int unsigned col_pos;
  logic [8:0]  survive_rule;
  logic [8:0]  birth_rule;
  logic [10:0] width_reg;
  logic [12:0] height_reg;

  cell_update_t pending_updates[$];
  int unsigned  mismatches;
  bit           no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // {survive, birth} of the classic rule variants
  function automatic logic [17:0] rule_pair(input int unsigned k);
    case (k)
      0:       return {9'd12,  9'd8};    // 23/3
      1:       return {9'd24,  9'd24};   // 34/34
      2:       return {9'd52,  9'd328};  // 245/368
      3:       return {9'd268, 9'd168};  // 238/357
      4:       return {9'd38,  9'd72};   // 125/36
      5:       return {9'd32,  9'd56};   // 5/345
      6:       return {9'd492, 9'd456};  // 235678/3678
      default: return {9'd511, 9'd2};    // 012345678/1
    endcase
  endfunction

  // Shift one cell into the grid model; returns 1 when an interior cell is updated
  function automatic bit next_generation(input logic alive, output cell_update_t upd);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned n;
    logic        above;
    logic        two_above;
    logic        centre;
    bit          produced;
    w = fit_size(width_reg, MaxWidth);
    h = fit_size(height_reg, MaxHeight);
    r = row_pos;
    c = col_pos;
    produced = 1'b0;
    upd = '0;
    above = above_row[c];
    two_above = two_above_row[c];
    two_above_row[c] = above;
    above_row[c] = alive;
    window_q = {window_q[5:0], two_above, above, alive};
    if (r >= 2 && c >= 2) begin
      centre = window_q[4];
      n = $countones(window_q) - centre;
      upd.row = 12'(r - 1);
      upd.col = 10'(c - 1);
      upd.count = 4'(n);
      upd.next = centre ? survive_rule[n] : birth_rule[n];
      upd.last = (r == h - 1) && (c == w - 1);
      produced = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
    return produced;
  endfunction

  // Register write; called at a falling edge while no transfer is pending
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgSurvive: survive_rule = value[8:0];
      CfgBirth:   birth_rule = value[8:0];
      CfgWidth: begin
        width_reg = value[10:0];
        row_pos = 0;
        col_pos = 0;
      end
      CfgHeight: begin
        height_reg = value;
        row_pos = 0;
        col_pos = 0;
      end
      default: ;
    endcase
  endtask

  // One input transfer; entered and left at a falling edge
  task automatic send_cell(input logic [7:0] data, input bit typed,
                           input cell_update_t typed_upd);
    cell_update_t upd;
    while (!no_gaps && $urandom_range(99) < GapPct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    if (next_generation(data[0], upd)) begin
      pending_updates = {pending_updates, typed ? typed_upd : upd};
    end
    @(negedge clk_i);
  endtask

  task automatic feed_cells(input int unsigned count, input int unsigned live_pct);
    cell_update_t none;
    logic [7:0]   d;
    none = '0;
    repeat (count) begin
      d = 8'($urandom);
      d[0] = ($urandom_range(99) < live_pct);
      send_cell(d, 1'b0, none);
    end
  endtask

  // Wait for every update to drain, then give the pipeline time to go quiet
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_updates.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_rules(input logic [8:0] survive, input logic [8:0] birth);
    logic [CfgW-1:0] v;
    v = CfgW'($urandom);
    v[8:0] = survive;
    write_reg(CfgSurvive, v);
    v = CfgW'($urandom);
    v[8:0] = birth;
    write_reg(CfgBirth, v);
  endtask

  // Output side: random stalls, compare each transfer with the oldest expected update
  initial begin
    cell_update_t want;
    cell_update_t got;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = no_gaps || ($urandom_range(99) >= GapPct);
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.row = m_axis_tdata[11:0];
        got.col = m_axis_tdata[21:12];
        got.count = m_axis_tdata[25:22];
        got.next = m_axis_tdata[26];
        got.last = m_axis_tlast;
        if (pending_updates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected update: row %0d col %0d count %0d next %0b last %0b",
                     got.row, got.col, got.count, got.next, got.last);
        end else begin
          want = pending_updates.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"update mismatch: expected row %0d col %0d count %0d next %0b ",
                        "last %0b, got row %0d col %0d count %0d next %0b last %0b"},
                       want.row, want.col, want.count, want.next, want.last,
                       got.row, got.col, got.count, got.next, got.last);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    frame_row_t      frame_table [3];
    cell_update_t    typed_upd;
    logic [17:0]     rules;
    logic [CfgW-1:0] v;
    int unsigned     random_sent;
    int unsigned     k;
    int unsigned     n;
    int unsigned     w;
    int unsigned     h;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgSurvive;
    cfg_data_i = '0;
    no_gaps = 1'b0;
    mismatches = 0;
    window_q = '0;
    row_pos = 0;
    col_pos = 0;
    survive_rule = RstSurvive;
    birth_rule = RstBirth;
    width_reg = 11'(RstGridWidth);
    height_reg = 13'(RstGridHeight);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: 3x3 grid (sizes below 3 clamp up), only 8 survives, only 0 gives birth.
    // Upper register bits carry noise that must be ignored.
    write_reg(CfgSurvive, 13'h1F00);
    write_reg(CfgBirth, 13'h1E01);
    write_reg(CfgWidth, 13'h0000);
    write_reg(CfgHeight, 13'h0002);
    frame_table[0] = {9'h1FF, 4'd8, 1'b1};  // full neighbourhood, live centre survives
    frame_table[1] = {9'h1EF, 4'd8, 1'b0};  // full neighbourhood, dead centre stays dead
    frame_table[2] = {9'h000, 4'd0, 1'b1};  // empty grid, birth on zero neighbours
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < 9; i++) begin
        typed_upd = {12'd1, 10'd1, frame_table[f].count, frame_table[f].next, 1'b1};
        send_cell({i[0] ? 7'h7F : 7'h00, frame_table[f].cells[i]}, i == 8, typed_upd);
      end
    end
    settle();

    // Widest grid: width overflows and clamps; a partial top row gives no updates
    rules = rule_pair(0);
    write_rules(rules[17:9], rules[8:0]);
    write_reg(CfgWidth, 13'h07FF);
    write_reg(CfgHeight, 13'd3);
    feed_cells(WideCells, 40);
    settle();

    // Tall grid, narrowest row; masks at their extremes; no stalls on either side
    no_gaps = 1'b1;
    write_reg(CfgSurvive, 13'h0000);
    write_reg(CfgBirth, 13'h01FF);
    write_reg(CfgWidth, 13'h0001);
    write_reg(CfgHeight, 13'h1FFF);
    feed_cells(TallCells, 50);
    settle();
    no_gaps = 1'b0;

    // Random phases over small grids and assorted rules
    random_sent = 0;
    while (random_sent < RandomCells) begin
      k = $urandom_range(9);
      if (k <= 6) begin
        if (k <= 4) begin
          rules = rule_pair($urandom_range(7));
          write_rules(rules[17:9], rules[8:0]);
        end else begin
          write_reg(CfgSurvive, CfgW'($urandom));
          write_reg(CfgBirth, CfgW'($urandom));
        end
        v = ($urandom_range(9) == 0) ? CfgW'($urandom_range(2)) : CfgW'($urandom_range(3, 16));
        write_reg(CfgWidth, v);
        v = ($urandom_range(9) == 0) ? CfgW'($urandom_range(2)) : CfgW'($urandom_range(3, 10));
        write_reg(CfgHeight, v);
        w = fit_size(width_reg, MaxWidth);
        h = fit_size(height_reg, MaxHeight);
        n = $urandom_range(w * h / 2, 3 * w * h);
      end else if (k == 7) begin
        // rule change mid-frame, no restart
        rules = rule_pair($urandom_range(7));
        write_rules(rules[17:9], rules[8:0]);
        n = $urandom_range(5, 60);
      end else if (k == 8) begin
        // same width written again still restarts the frame
        write_reg(CfgWidth, {2'b00, width_reg});
        n = $urandom_range(5, 60);
      end else begin
        // raw register noise, usually a large grid; short run
        write_reg(CfgWidth, CfgW'($urandom));
        write_reg(CfgHeight, CfgW'($urandom));
        n = $urandom_range(10, 40);
      end
      // keep the total close to the planned item count
      if (n > RandomCells - random_sent) n = RandomCells - random_sent;
      feed_cells(n, $urandom_range(5, 95));
      random_sent += n;
      settle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
